### rtl/core/burts_pkg.sv
// Shared types and constants for the buffered UART core with nRTS flow control.
// No dependencies.
package burts_pkg;

  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LVL_W      = 7;
  localparam int unsigned CMP_W      = (CNT_W > LVL_W) ? CNT_W : LVL_W;

  localparam logic [LVL_W-1:0] HW_RESET   = 7'd48;
  localparam logic [7:0]       EMPTY_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_HOST_RD = 2'd1,
    CMD_HOST_WR = 2'd2,
    CMD_TX_RDY  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

### rtl/core/burts_if.sv
// Item and result channel interfaces for the buffered UART core.
// Depends on burts_pkg.
interface burts_item_if;
  logic              valid;
  logic              ready;
  burts_pkg::cmd_e   cmd;
  logic [7:0]        byte_in;

  modport source (output valid, cmd, byte_in, input ready);
  modport sink   (input valid, cmd, byte_in, output ready);
endinterface

interface burts_result_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    read_byte;
  logic                          read_valid;
  logic [7:0]                    send_byte;
  logic                          send_valid;
  logic                          write_accepted;
  logic                          rts_n;
  logic                          overflow;
  logic                          tx_armed;
  logic [burts_pkg::LVL_W-1:0]   rx_level;
  logic [burts_pkg::LVL_W-1:0]   tx_level;

  modport source (output valid, read_byte, read_valid, send_byte, send_valid,
                  write_accepted, rts_n, overflow, tx_armed, rx_level, tx_level,
                  input ready);
  modport sink   (input valid, read_byte, read_valid, send_byte, send_valid,
                  write_accepted, rts_n, overflow, tx_armed, rx_level, tx_level,
                  output ready);
endinterface

### rtl/core/burts_fifo.sv
// Byte FIFO: synchronous memory with head/tail pointers and a fill count.
// Read data is registered in the cycle after a pop. Depends on burts_pkg.
module burts_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  burts_pkg::fifo_ctrl_t       ctrl_i,
  input  logic [7:0]                  wdata_i,
  output logic [burts_pkg::CNT_W-1:0] count_o,
  output logic [7:0]                  rdata_o
);
  import burts_pkg::*;

  logic [7:0]       mem_q [FIFO_DEPTH];
  logic [7:0]       rdata_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    head_d  = ctrl_i.pop  ? ptr_inc(head_q) : head_q;
    tail_d  = ctrl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule

### rtl/core/buffered_uart_rts_flow_control_core.sv
// Top level of the buffered UART core: receive and transmit FIFOs, nRTS flow
// control, overflow and transmitter-armed flags. Depends on burts_pkg,
// burts_if and burts_fifo.
//
//   port        dir  kind        contents
//   item_i      in   valid/ready cmd, byte_in
//   result_o    out  valid/ready read/send bytes, flags, levels
//   hw_we_i     in   write en    high-water register write
//   hw_wdata_i  in   data        new high-water value
//
// One item per cycle. Control state updates at acceptance; a FIFO pop reads
// its memory in the same edge and the byte appears with the result, from the
// FIFO read register. An item is taken while the result register is empty
// or its result is taken in the same cycle. Reset clears pointers, counts
// and flags; FIFO memories are not cleared.
module buffered_uart_rts_flow_control_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  burts_item_if.sink                  item_i,
  burts_result_if.source              result_o,
  input  logic                        hw_we_i,
  input  logic [burts_pkg::LVL_W-1:0] hw_wdata_i
);
  import burts_pkg::*;

  logic [LVL_W-1:0] hw_q;
  logic             rts_q, rts_d;
  logic             ovf_q, ovf_d;
  logic             armed_q, armed_d;

  logic             res_valid_q;
  logic             rd_pop_q, rd_pop_d;
  logic             rd_empty_q, rd_empty_d;
  logic             sd_pop_q, sd_pop_d;
  logic             wr_ok_q, wr_ok_d;

  fifo_ctrl_t       rx_ctrl, tx_ctrl;
  logic [CNT_W-1:0] rx_count, tx_count, rx_next;
  logic [7:0]       rx_rdata, tx_rdata;
  logic             rx_full, rx_empty, tx_full, tx_empty;
  logic             accept;

  burts_fifo u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl),
    .wdata_i (item_i.byte_in),
    .count_o (rx_count),
    .rdata_o (rx_rdata)
  );

  burts_fifo u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl),
    .wdata_i (item_i.byte_in),
    .count_o (tx_count),
    .rdata_o (tx_rdata)
  );

  assign rx_full  = (rx_count == CNT_W'(FIFO_DEPTH));
  assign rx_empty = (rx_count == '0);
  assign tx_full  = (tx_count == CNT_W'(FIFO_DEPTH));
  assign tx_empty = (tx_count == '0);

  assign item_i.ready = !res_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    rx_ctrl    = '0;
    tx_ctrl    = '0;
    rts_d      = rts_q;
    ovf_d      = ovf_q;
    armed_d    = armed_q;
    rd_pop_d   = 1'b0;
    rd_empty_d = 1'b0;
    sd_pop_d   = 1'b0;
    wr_ok_d    = 1'b0;
    rx_next    = rx_count;
    case (item_i.cmd)
      CMD_RX_BYTE: begin
        if (rx_full) begin
          ovf_d = 1'b1;
        end else begin
          rx_ctrl.push = 1'b1;
          rx_next      = rx_count + CNT_W'(1);
        end
        if (CMP_W'(rx_next) > CMP_W'(hw_q)) begin
          rts_d = 1'b1;
        end
      end
      CMD_HOST_RD: begin
        if (rx_empty) begin
          rd_empty_d = 1'b1;
        end else begin
          rx_ctrl.pop = 1'b1;
          rd_pop_d    = 1'b1;
          rx_next     = rx_count - CNT_W'(1);
          if (CMP_W'(rx_next) <= CMP_W'(hw_q)) begin
            rts_d = 1'b0;
          end
        end
      end
      CMD_HOST_WR: begin
        if (!tx_full) begin
          tx_ctrl.push = 1'b1;
          armed_d      = 1'b1;
          wr_ok_d      = 1'b1;
        end
      end
      CMD_TX_RDY: begin
        if (armed_q) begin
          if (tx_empty) begin
            armed_d = 1'b0;
          end else begin
            tx_ctrl.pop = 1'b1;
            sd_pop_d    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      rx_ctrl = '0;
      tx_ctrl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= HW_RESET;
      rts_q       <= 1'b0;
      ovf_q       <= 1'b0;
      armed_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (hw_we_i) begin
        hw_q <= hw_wdata_i;
      end
      if (accept) begin
        rts_q   <= rts_d;
        ovf_q   <= ovf_d;
        armed_q <= armed_d;
      end
      if (item_i.ready) begin
        res_valid_q <= item_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_pop_q   <= rd_pop_d;
      rd_empty_q <= rd_empty_d;
      sd_pop_q   <= sd_pop_d;
      wr_ok_q    <= wr_ok_d;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.read_byte      = rd_pop_q ? rx_rdata : (rd_empty_q ? EMPTY_BYTE : 8'h00);
  assign result_o.read_valid     = rd_pop_q;
  assign result_o.send_byte      = sd_pop_q ? tx_rdata : 8'h00;
  assign result_o.send_valid     = sd_pop_q;
  assign result_o.write_accepted = wr_ok_q;
  assign result_o.rts_n          = rts_q;
  assign result_o.overflow       = ovf_q;
  assign result_o.tx_armed       = armed_q;
  assign result_o.rx_level       = LVL_W'(rx_count);
  assign result_o.tx_level       = LVL_W'(tx_count);

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_rts_rise_on_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rts_q) |-> $past(accept && item_i.cmd == CMD_RX_BYTE))
    else $error("nRTS raised by something other than a received byte");

  a_send_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && sd_pop_q) |-> armed_q)
    else $error("byte sent while transmitter disarmed");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !result_o.ready) |=> ($stable(rx_count) && $stable(tx_count)))
    else $error("FIFO level moved while result stalled");

  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_count <= CNT_W'(FIFO_DEPTH)) && (tx_count <= CNT_W'(FIFO_DEPTH)))
    else $error("FIFO count beyond depth");

endmodule
